>>> rtl/assert_macros.svh
// Assertion helpers for the lookahead waypoint search.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define LWP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define LWP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/lwp_pkg.sv
// ----------------------------------------------------------------------------
// Lookahead waypoint search package
// Transfer types, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package lwp_pkg;

    localparam int SLOT_W = 12;
    localparam int CNT_W  = 13;
    localparam int SPAN_W = 16;
    localparam int LA_W   = 31;
    localparam int CFG_W  = 3;

    localparam logic [CFG_W-1:0] CFG_WAYPOINT_COUNT  = 3'd0;
    localparam logic [CFG_W-1:0] CFG_SEARCH_SPAN     = 3'd1;
    localparam logic [CFG_W-1:0] CFG_MIN_LOOKAHEAD   = 3'd2;
    localparam logic [CFG_W-1:0] CFG_MAX_LOOKAHEAD   = 3'd3;
    localparam logic [CFG_W-1:0] CFG_LOOKAHEAD_RATIO = 3'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_POSE = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [SLOT_W-1:0]  waypoint_slot;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] current_speed;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] target_index;
        logic              target_found;
        logic [SLOT_W-1:0] nearest_index;
    } t_out;

endpackage

>>> rtl/lwp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lwp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/lwp_div.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lwp_div #(
    parameter int NW = 63,
    parameter int DW = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

>>> rtl/lookahead_waypoint_search.sv
// ----------------------------------------------------------------------------
// Lookahead waypoint search
// A load transfer on the input channel writes one waypoint into the table and
// gives no result. A pose transfer starts a search that gives one result.
// The configuration channel is always ready; the user must see that it is
// written only while idle, as the block itself does not enforce this. A pose
// first streams all n loaded entries (n is the saturated waypoint count)
// through the distance pipeline to find the nearest one, then streams span
// mod n entries from there, wrapping, to pick the farthest point ahead within
// the lookahead distance. The table memory delivers one entry a cycle; the
// pipeline fill and the lookahead divider add to the search time, the divider
// overlapping the nearest-point walk. A load leaves the block idle.
// The input channel is not ready while a pose is in progress. The result sits
// in an output register; a stalled receiver holds the block once the next
// search has finished. Reset restores the register defaults and clears the
// held target, but leaves the table contents undefined.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lookahead_waypoint_search #(
    parameter int MAX_WAYPOINTS = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lwp_pkg::CFG_W-1:0]  i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  lwp_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lwp_pkg::t_out              o_out
);
    import lwp_pkg::*;

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int NB = $clog2(MAX_WAYPOINTS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_NEAR  = 3'd2;
    localparam logic [2:0] ST_NWAIT = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_SWAIT = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic [SPAN_W-1:0] r_span;
    logic [LA_W-1:0]   r_min;
    logic [LA_W-1:0]   r_max;
    logic [LA_W-1:0]   r_ratio;

    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_hx;
    logic signed [31:0] r_hy;
    logic signed [63:0] r_prod;
    logic               r_neg;

    logic [AW-1:0] r_addr;
    logic [NB-1:0] r_left;
    logic [NB-1:0] w_n;
    logic [AW-1:0] w_next_addr;
    logic          w_issue;
    logic          w_pipe_empty;
    logic          w_in_acc;
    logic          w_done_fire;
    logic          w_start;

    logic          r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [AW-1:0] r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx;
    logic [63:0]   w_rdata;
    logic          w_we;

    logic signed [32:0] r_dx, r_dy;
    logic [31:0]        w_ax, w_ay;
    logic [32:0]        w_nx, w_ny;
    logic [31:0]        r_xhh, r_xhl, r_xll, r_yhh, r_yhl, r_yll;
    logic signed [16:0] w_dxh, w_dxl, w_dyh, w_dyl;
    logic signed [48:0] r_pxh, r_pxl, r_pyh, r_pyl;
    logic [63:0]        w_sqx, w_sqy;
    logic signed [65:0] w_dot;
    logic [64:0]        r_s4_d;
    logic               r_s4_ahead;

    logic               r_near_any;
    logic [64:0]        r_near_d;
    logic [AW-1:0]      r_near_idx;
    logic               r_found;
    logic [63:0]        r_far_d;
    logic [AW-1:0]      r_best;
    logic [SLOT_W-1:0]  r_held;

    logic               r_out_v;
    t_out               r_out;

    logic [62:0]        w_num;
    logic [LA_W-1:0]    w_den;
    logic               w_la_done;
    logic [62:0]        w_quo;
    logic [LA_W-1:0]    w_la_rem;
    logic               w_sp_done;
    logic [SPAN_W-1:0]  w_sp_quo;
    logic [NB-1:0]      w_sp_rem;
    logic [62:0]        w_la1;
    logic [LA_W-1:0]    w_la;
    logic [LA_W-1:0]    r_la;
    logic               r_la_v;
    logic [61:0]        r_la2;
    logic               r_la2_v;

    logic signed [31:0] w_qyy, w_qzz, w_qzw, w_qxy;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_done_fire = (r_state == ST_DONE) && (!r_out_v || i_out_ready);
    assign w_start     = (r_state == ST_SETUP);
    assign w_issue     = (r_state == ST_NEAR) || (r_state == ST_SCAN);
    assign w_pipe_empty = !r_s1_v && !r_s2_v && !r_s3_v && !r_s4_v;

    assign w_n = (r_count == '0) ? NB'(1) :
                 (32'(r_count) > 32'(MAX_WAYPOINTS)) ? NB'(MAX_WAYPOINTS) : NB'(r_count);
    assign w_next_addr = (r_addr == AW'(w_n - 1'b1)) ? '0 : r_addr + 1'b1;

    assign w_qyy = i_in.quat_y * i_in.quat_y;
    assign w_qzz = i_in.quat_z * i_in.quat_z;
    assign w_qzw = i_in.quat_z * i_in.quat_w;
    assign w_qxy = i_in.quat_x * i_in.quat_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(1);
            r_span  <= SPAN_W'(500);
            r_min   <= LA_W'(32768);
            r_max   <= LA_W'(65536);
            r_ratio <= LA_W'(524288);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WAYPOINT_COUNT:  r_count <= i_cfg_data[CNT_W-1:0];
                CFG_SEARCH_SPAN:     r_span  <= i_cfg_data[SPAN_W-1:0];
                CFG_MIN_LOOKAHEAD:   r_min   <= i_cfg_data[LA_W-1:0];
                CFG_MAX_LOOKAHEAD:   r_max   <= i_cfg_data[LA_W-1:0];
                CFG_LOOKAHEAD_RATIO: r_ratio <= i_cfg_data[LA_W-1:0];
                default: ;
            endcase
        end
    end

    // Table memory: x in the upper half, y in the lower half.
    assign w_we = w_in_acc && (i_in.operation == OP_LOAD) &&
                  (32'(i_in.waypoint_slot) < 32'(MAX_WAYPOINTS));

    lwp_ram #(
        .WIDTH (64),
        .DEPTH (MAX_WAYPOINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_in.waypoint_slot)),
        .i_wdata ({i_in.point_x, i_in.point_y}),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_num = r_prod[63] ? 63'(-r_prod) : r_prod[62:0];
    assign w_den = (r_ratio == '0) ? LA_W'(1) : r_ratio;

    lwp_div #(
        .NW (63),
        .DW (LA_W)
    ) u_div_la (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_la_done),
        .o_quo   (w_quo),
        .o_rem   (w_la_rem)
    );

    lwp_div #(
        .NW (SPAN_W),
        .DW (NB)
    ) u_div_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (r_span),
        .i_den   (w_n),
        .o_done  (w_sp_done),
        .o_quo   (w_sp_quo),
        .o_rem   (w_sp_rem)
    );

    assign w_la1 = ((r_neg && w_quo != '0) || (w_quo < 63'(r_min))) ? 63'(r_min) : w_quo;
    assign w_la  = (w_la1 > 63'(r_max)) ? r_max : w_la1[LA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_la_v  <= 1'b0;
            r_la2_v <= 1'b0;
            r_out_v <= 1'b0;
            r_held  <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
        end else begin
            r_s1_v  <= w_issue;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_la2_v <= r_la_v;
            if (w_done_fire) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if ((r_state == ST_NEAR || r_state == ST_NWAIT) && w_la_done && !r_la_v) begin
                r_la_v <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && i_in.operation == OP_POSE) begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_la_v  <= 1'b0;
                    r_la2_v <= 1'b0;
                    r_state <= ST_NEAR;
                end
                ST_NEAR: begin
                    if (r_left == NB'(1)) begin
                        r_state <= ST_NWAIT;
                    end
                end
                ST_NWAIT: begin
                    if (w_pipe_empty && r_la2_v && w_sp_done) begin
                        r_state <= (w_sp_rem == '0) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_left == NB'(1)) begin
                        r_state <= ST_SWAIT;
                    end
                end
                ST_SWAIT: begin
                    if (w_pipe_empty) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_done_fire) begin
                        r_state <= ST_IDLE;
                        if (r_found) begin
                            r_held <= SLOT_W'(r_best);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px   <= i_in.point_x;
            r_py   <= i_in.point_y;
            r_prod <= $signed({1'b0, r_max}) * i_in.current_speed;
            r_hx   <= 32'sd134217728 - (w_qyy + w_qzz);
            r_hy   <= w_qzw + w_qxy;
        end
        if (r_state == ST_SETUP) begin
            r_neg      <= r_prod[63];
            r_addr     <= '0;
            r_left     <= w_n;
            r_near_any <= 1'b0;
            r_found    <= 1'b0;
            r_far_d    <= '0;
            if (r_hx == '0 && r_hy == '0) begin
                r_hx <= 32'sd1;
            end
        end
        if ((r_state == ST_NEAR || r_state == ST_NWAIT) && w_la_done && !r_la_v) begin
            r_la <= w_la;
        end
        r_la2 <= r_la * r_la;
        if (r_state == ST_NWAIT && w_pipe_empty && r_la2_v && w_sp_done) begin
            r_addr <= r_near_idx;
            r_left <= w_sp_rem;
        end
        if (w_issue) begin
            r_addr <= w_next_addr;
            r_left <= r_left - 1'b1;
        end

        // Distance pipeline.
        r_s1_idx <= r_addr;
        r_s2_idx <= r_s1_idx;
        r_s3_idx <= r_s2_idx;
        r_s4_idx <= r_s3_idx;
        r_dx <= 33'(signed'(w_rdata[63:32])) - 33'(r_px);
        r_dy <= 33'(signed'(w_rdata[31:0])) - 33'(r_py);
        r_xhh <= w_ax[31:16] * w_ax[31:16];
        r_xhl <= w_ax[31:16] * w_ax[15:0];
        r_xll <= w_ax[15:0] * w_ax[15:0];
        r_yhh <= w_ay[31:16] * w_ay[31:16];
        r_yhl <= w_ay[31:16] * w_ay[15:0];
        r_yll <= w_ay[15:0] * w_ay[15:0];
        r_pxh <= w_dxh * r_hx;
        r_pxl <= w_dxl * r_hx;
        r_pyh <= w_dyh * r_hy;
        r_pyl <= w_dyl * r_hy;
        r_s4_d     <= 65'(w_sqx) + 65'(w_sqy);
        r_s4_ahead <= (w_dot > 66'sd0);

        // Nearest and farthest selection.
        if (r_s4_v) begin
            if (r_state == ST_NEAR || r_state == ST_NWAIT) begin
                if (!r_near_any || r_s4_d < r_near_d) begin
                    r_near_any <= 1'b1;
                    r_near_d   <= r_s4_d;
                    r_near_idx <= r_s4_idx;
                end
            end else if (r_s4_ahead && !r_s4_d[64] && r_s4_d[63:0] <= 64'(r_la2) &&
                         r_far_d < r_s4_d[63:0]) begin
                r_found <= 1'b1;
                r_far_d <= r_s4_d[63:0];
                r_best  <= r_s4_idx;
            end
        end

        if (w_done_fire) begin
            r_out.target_index  <= r_found ? SLOT_W'(r_best) : r_held;
            r_out.target_found  <= r_found;
            r_out.nearest_index <= SLOT_W'(r_near_idx);
        end
    end

    assign w_nx  = -r_dx;
    assign w_ny  = -r_dy;
    assign w_ax  = r_dx[32] ? w_nx[31:0] : r_dx[31:0];
    assign w_ay  = r_dy[32] ? w_ny[31:0] : r_dy[31:0];
    assign w_dxh = r_dx[32:16];
    assign w_dxl = signed'({1'b0, r_dx[15:0]});
    assign w_dyh = r_dy[32:16];
    assign w_dyl = signed'({1'b0, r_dy[15:0]});
    assign w_sqx = (64'(r_xhh) << 32) + (64'(r_xhl) << 17) + 64'(r_xll);
    assign w_sqy = (64'(r_yhh) << 32) + (64'(r_yhl) << 17) + 64'(r_yll);
    assign w_dot = (66'(r_pxh) <<< 16) + 66'(r_pxl) + (66'(r_pyh) <<< 16) + 66'(r_pyl);

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    `LWP_ASSERT(a_idle_pipe_empty, i_clk, i_rst_n,
        (r_state == ST_IDLE) |-> (!r_s2_v && !r_s3_v && !r_s4_v), "pipeline busy while idle")
    `LWP_ASSERT(a_scan_after_lookahead, i_clk, i_rst_n,
        (r_state == ST_SCAN) |-> (r_la2_v && w_sp_done), "scan before lookahead ready")
    `LWP_ASSERT(a_result_from_done, i_clk, i_rst_n,
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE), "result without finished search")
endmodule

>>> sim/lookahead_waypoint_search_test.sv
// ----------------------------------------------------------------------------
// Lookahead waypoint search testbench
// Loads waypoint tables and sends poses. Each result is checked against a
// built-in model of the nearest-point and lookahead search, or its directed
// row's result. A short directed table comes first, then random phases with
// many table sizes and register settings, and finally a full 4096-entry table.
// Both channels pause at random; the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module lookahead_waypoint_search_test;
    timeunit 1ns;
    timeprecision 1ps;
    import lwp_pkg::*;

    localparam int DEPTH = 4096;
    localparam int M = 65536;
    localparam longint LIMIT = 1_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    t_in                in_bus;
    logic               out_valid;
    logic               out_ready;
    t_out               out_bus;

    lookahead_waypoint_search #(.MAX_WAYPOINTS(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in(in_bus),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out(out_bus)
    );

    // Model state.
    logic signed [31:0] table_x [DEPTH];
    logic signed [31:0] table_y [DEPTH];
    logic [SLOT_W-1:0]  held_target;
    logic [CNT_W-1:0]   count_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic [LA_W-1:0]    min_la_reg;
    logic [LA_W-1:0]    max_la_reg;
    logic [LA_W-1:0]    ratio_reg;

    t_out   search_results_q[$];
    int     errors;
    int     results_seen;
    longint cycles;
    bit     burst_mode;

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] reg_index;
        logic [31:0]      reg_data;
        t_in              item;
        bit               typed;
        t_out             result;
    } row_t;

    row_t directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin
        while (cycles <= LIMIT) @(posedge i_clk);
        $display("lookahead_waypoint_search_test NOT OK");
        $finish;
    end

    function automatic logic [65:0] dist_sq(longint dx, longint dy);
        logic [65:0] ax;
        logic [65:0] ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        return ax * ax + ay * ay;
    endfunction

    function automatic t_out search_pose(t_in it);
        int unsigned n;
        int unsigned scan;
        int unsigned idx;
        int unsigned nearest;
        int unsigned best;
        logic [65:0] d;
        logic [65:0] near_d;
        logic [65:0] far_d;
        logic [65:0] la2;
        logic [65:0] la_w;
        longint px, py, dx, dy, hx, hy, qx, qy, qz, qw, la, divisor, p, q;
        bit found;
        t_out r;
        n = count_reg;
        if (n == 0) n = 1;
        if (n > DEPTH) n = DEPTH;
        px = longint'(it.point_x);
        py = longint'(it.point_y);
        nearest = 0;
        near_d = dist_sq(longint'(table_x[0]) - px, longint'(table_y[0]) - py);
        for (int unsigned i = 1; i < n; i++) begin
            d = dist_sq(longint'(table_x[i]) - px, longint'(table_y[i]) - py);
            if (d < near_d) begin
                near_d = d;
                nearest = i;
            end
        end
        divisor = (ratio_reg == 0) ? 1 : longint'(ratio_reg);
        la = (longint'(max_la_reg) * longint'(it.current_speed)) / divisor;
        if (la < longint'(min_la_reg)) la = longint'(min_la_reg);
        if (la > longint'(max_la_reg)) la = longint'(max_la_reg);
        la_w = la;
        la2 = la_w * la_w;
        qx = longint'(it.quat_x);
        qy = longint'(it.quat_y);
        qz = longint'(it.quat_z);
        qw = longint'(it.quat_w);
        hx = (longint'(1) << 27) - (qy * qy + qz * qz);
        hy = qz * qw + qx * qy;
        if (hx == 0 && hy == 0) hx = 1;
        scan = span_reg % n;
        idx = nearest;
        found = 1'b0;
        best = 0;
        far_d = '0;
        for (int unsigned k = 0; k < scan; k++) begin
            dx = longint'(table_x[idx]) - px;
            dy = longint'(table_y[idx]) - py;
            p = dx * hx;
            q = -(dy * hy);
            if (p > q) begin
                d = dist_sq(dx, dy);
                if (d <= la2 && far_d < d) begin
                    far_d = d;
                    best = idx;
                    found = 1'b1;
                end
            end
            idx++;
            if (idx >= n) idx = 0;
        end
        if (found) held_target = best[SLOT_W-1:0];
        r.target_index = held_target;
        r.target_found = found;
        r.nearest_index = nearest[SLOT_W-1:0];
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int idle_draw();
        if (burst_mode) return 0;
        return $urandom_range(0, 10);
    endfunction

    function automatic logic signed [31:0] near_coord(int unsigned span_m);
        return int'($urandom_range(0, 2 * span_m * M)) - int'(span_m * M);
    endfunction

    function automatic logic signed [15:0] rand_quat();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic t_in make_item(logic op, int slot, int x, int y);
        t_in it;
        it.operation = op;
        it.waypoint_slot = slot;
        it.point_x = x;
        it.point_y = y;
        it.quat_x = rand_quat();
        it.quat_y = rand_quat();
        it.quat_z = rand_quat();
        it.quat_w = rand_quat();
        it.current_speed = $urandom;
        return it;
    endfunction

    function automatic row_t load_row(int slot, int x, int y);
        row_t r;
        r.is_cfg = 1'b0;
        r.typed = 1'b0;
        r.item = make_item(OP_LOAD, slot, x, y);
        return r;
    endfunction

    function automatic row_t pose_row(int x, int y, int qx, int qy, int qz, int qw, int spd);
        row_t r;
        r.is_cfg = 1'b0;
        r.typed = 1'b0;
        r.item = make_item(OP_POSE, $urandom_range(0, 4095), x, y);
        r.item.quat_x = qx;
        r.item.quat_y = qy;
        r.item.quat_z = qz;
        r.item.quat_w = qw;
        r.item.current_speed = spd;
        return r;
    endfunction

    function automatic row_t pose_row_exp(int x, int y, int qx, int qy, int qz, int qw,
                                          int spd, int tgt, bit fnd, int nr);
        row_t r;
        r = pose_row(x, y, qx, qy, qz, qw, spd);
        r.typed = 1'b1;
        r.result.target_index = tgt;
        r.result.target_found = fnd;
        r.result.nearest_index = nr;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [CFG_W-1:0] idx, logic [31:0] data);
        row_t r;
        r.is_cfg = 1'b1;
        r.reg_index = idx;
        r.reg_data = data;
        r.typed = 1'b0;
        return r;
    endfunction

    task automatic send_item(t_in it, bit typed = 1'b0, t_out typed_result = '0);
        int gap;
        t_out r;
        gap = idle_draw();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_bus <= it;
        do @(posedge i_clk); while (!in_ready);
        if (it.operation == OP_LOAD) begin
            table_x[it.waypoint_slot] = it.point_x;
            table_y[it.waypoint_slot] = it.point_y;
        end else begin
            r = search_pose(it);
            search_results_q.push_back(typed ? typed_result : r);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (search_results_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_WAYPOINT_COUNT:  count_reg = data[CNT_W-1:0];
            CFG_SEARCH_SPAN:     span_reg = data[SPAN_W-1:0];
            CFG_MIN_LOOKAHEAD:   min_la_reg = data[LA_W-1:0];
            CFG_MAX_LOOKAHEAD:   max_la_reg = data[LA_W-1:0];
            CFG_LOOKAHEAD_RATIO: ratio_reg = data[LA_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pose_near(int unsigned span_m);
        t_in it;
        it = make_item(OP_POSE, $urandom_range(0, 4095), near_coord(span_m), near_coord(span_m));
        if ($urandom_range(0, 9) == 0) begin
            it.point_x = $urandom;
            it.point_y = $urandom;
        end else begin
            it.current_speed = int'($urandom_range(0, 16 * M)) - 4 * M;
        end
        send_item(it);
    endtask

    // Result side: random pauses, one long stall, and the checks.
    initial begin
        int gap;
        t_out want;
        out_ready = 1'b0;
        forever begin
            gap = (results_seen == 15) ? 400 : idle_draw();
            @(negedge i_clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            results_seen++;
            if (search_results_q.size() == 0) begin
                $display("unexpected result transfer at cycle %0d", cycles);
                errors++;
            end else begin
                want = search_results_q.pop_front();
                if (out_bus.target_index !== want.target_index)
                    report("target_index", out_bus.target_index, want.target_index);
                if (out_bus.target_found !== want.target_found)
                    report("target_found", out_bus.target_found, want.target_found);
                if (out_bus.nearest_index !== want.nearest_index)
                    report("nearest_index", out_bus.nearest_index, want.nearest_index);
            end
        end
    end

    initial begin
        burst_mode = 1'b0;
        forever begin
            repeat (200) @(posedge i_clk);
            burst_mode = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int unsigned n;
        int unsigned span_m;
        cycles = 0;
        errors = 0;
        results_seen = 0;
        i_rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_bus = '0;
        held_target = '0;
        count_reg = 1;
        span_reg = 500;
        min_la_reg = 32768;
        max_la_reg = 65536;
        ratio_reg = 524288;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_rows = '{
            load_row(0, 0, 0),
            pose_row_exp(0, 0, 0, 0, 0, 16384, M, 0, 1'b0, 0),
            load_row(4095, 32'h7fffffff, 32'h80000000),
            load_row(0, 32'h80000000, 32'h7fffffff),
            pose_row(32'h7fffffff, 32'h80000000, 16384, -16384, 16384, -16384, 32'h80000000),
            pose_row(32'h80000000, 32'h7fffffff, -16384, -16384, -16384, -16384, 32'h7fffffff),
            cfg_row(CFG_WAYPOINT_COUNT, 4),
            cfg_row(CFG_SEARCH_SPAN, 3),
            cfg_row(CFG_MIN_LOOKAHEAD, 0),
            cfg_row(CFG_MAX_LOOKAHEAD, 4 * M),
            cfg_row(CFG_LOOKAHEAD_RATIO, M),
            load_row(0, 0, 0),
            load_row(1, M, 0),
            load_row(2, 3 * M, 0),
            load_row(3, 5 * M, 0),
            pose_row_exp(0, 0, 0, 0, 0, 16384, 2 * M, 2, 1'b1, 0),
            pose_row_exp(0, 0, 0, 0, 16384, 0, 2 * M, 2, 1'b0, 0),
            pose_row_exp(0, 0, 8192, 8192, 8192, -8192, 2 * M, 2, 1'b1, 0),
            pose_row(M / 2, 0, 0, 0, 0, 16384, M / 4),
            cfg_row(CFG_LOOKAHEAD_RATIO, 0),
            pose_row(0, 0, 0, 0, 0, 16384, M),
            cfg_row(CFG_MIN_LOOKAHEAD, 32'h7fffffff),
            pose_row(-M, 0, 0, 0, 0, 16384, 0),
            cfg_row(CFG_SEARCH_SPAN, 0),
            pose_row_exp(0, 0, 0, 0, 0, 16384, M, 2, 1'b0, 0)
        };
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_idle();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].result);
            end
        end

        for (int ph = 0; ph < 10; ph++) begin
            n = (ph == 3) ? 1 : $urandom_range(2, 24);
            span_m = $urandom_range(1, 12);
            wait_idle();
            write_reg(CFG_WAYPOINT_COUNT, n);
            write_reg(CFG_SEARCH_SPAN, (ph == 5) ? 32'hffff : $urandom_range(0, 2 * n));
            write_reg(CFG_MIN_LOOKAHEAD, $urandom_range(0, 2 * M));
            write_reg(CFG_MAX_LOOKAHEAD, $urandom_range(M, 10 * M));
            write_reg(CFG_LOOKAHEAD_RATIO, $urandom_range(M / 4, 8 * M));
            for (int s = 0; s < n; s++)
                send_item(make_item(OP_LOAD, s, near_coord(span_m), near_coord(span_m)));
            for (int k = 0; k < 10; k++) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(make_item(OP_LOAD, $urandom_range(0, n - 1),
                                        near_coord(span_m), near_coord(span_m)));
                send_pose_near(span_m);
            end
        end

        // Full table: every slot written, then the largest counts and finally a zero count.
        wait_idle();
        for (int s = 0; s < DEPTH; s++)
            send_item(make_item(OP_LOAD, s, $urandom, $urandom));
        wait_idle();
        write_reg(CFG_WAYPOINT_COUNT, DEPTH);
        write_reg(CFG_SEARCH_SPAN, 32'hffff);
        write_reg(CFG_MIN_LOOKAHEAD, 0);
        write_reg(CFG_MAX_LOOKAHEAD, 32'h7fffffff);
        write_reg(CFG_LOOKAHEAD_RATIO, 32'h7fffffff);
        send_pose_near(12);
        send_item(make_item(OP_POSE, 0, $urandom, $urandom));
        wait_idle();
        write_reg(CFG_WAYPOINT_COUNT, 8191);
        write_reg(CFG_LOOKAHEAD_RATIO, 1);
        send_item(make_item(OP_POSE, 0, $urandom, $urandom));
        wait_idle();
        write_reg(CFG_SEARCH_SPAN, DEPTH);
        send_pose_near(12);
        wait_idle();
        write_reg(CFG_WAYPOINT_COUNT, 0);
        send_pose_near(12);

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("lookahead_waypoint_search_test OK");
        else
            $display("lookahead_waypoint_search_test NOT OK");
        $finish;
    end

endmodule
